### design/lowest_free_id_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lowest free id tracker
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_TRACKER_CORE_ASSERT_SVH
`define LOWEST_FREE_ID_TRACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define LFID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfid assertion failed");

// Check that cons holds in the cycle after ante.
`define LFID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfid assertion failed");

`else

`define LFID_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define LFID_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/lfid_pkg.sv
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared types and constants of the lowest free id tracker.
// ----------------------------------------------------------------------------
package lfid_pkg;

  // Occupancy map word: 32 ids per word.
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  // Width of the id and mark fields on the ports.
  localparam int FIELD_W = 11;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_DEL = 1'b1;

  typedef enum logic {
    DIR_UP,
    DIR_DOWN
  } lfid_dir_e;

  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] ident;
  } lfid_req_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] lowest_free;
    logic [FIELD_W-1:0] highest_used;
  } lfid_rsp_t;

endpackage

### design/lfid_ram.sv
// ----------------------------------------------------------------------------
// lfid_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lfid_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/lfid_pick.sv
// ----------------------------------------------------------------------------
// lfid_pick
// Priority encoder over one map word: lowest set bit going up, highest
// set bit going down.
// ----------------------------------------------------------------------------
module lfid_pick (
  input  logic [lfid_pkg::WORD_W-1:0] vec_i,
  input  lfid_pkg::lfid_dir_e         dir_i,
  output logic                        found_o,
  output logic [lfid_pkg::BIT_W-1:0]  pos_o
);

  import lfid_pkg::*;

  logic [BIT_W-1:0] pos_lo;
  logic [BIT_W-1:0] pos_hi;

  // Last match wins: walk down for the lowest, up for the highest.
  always_comb begin
    pos_lo = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        pos_lo = BIT_W'(i);
      end
    end
  end

  always_comb begin
    pos_hi = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (vec_i[i]) begin
        pos_hi = BIT_W'(i);
      end
    end
  end

  assign found_o = |vec_i;
  assign pos_o   = (dir_i == DIR_UP) ? pos_lo : pos_hi;

endmodule

### design/lowest_free_id_tracker_core.sv
// ----------------------------------------------------------------------------
// lowest_free_id_tracker_core
// Occupancy map of ids 1..ID_COUNT with lowest free and highest used marks.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer one add or delete; the result
// (ok, lowest free id, highest used id) appears on rsp_o for exactly one
// cycle with done_o high, and the receiver cannot stall it. The map lives
// in a RAM of 32-bit words; one priority encoder is reused to scan it word
// by word. An operation that needs no scan, or whose next mark lies in the
// same word, finishes in the operation state, after the id's word is read
// in idle; each further word is read and scanned in the scan state.
// The scan rate is set by the single RAM read port. After reset the block
// clears the map word by word with busy high. Ids of 0 or above ID_COUNT
// give ok low and leave the state unchanged.
// ----------------------------------------------------------------------------
`include "lowest_free_id_tracker_core_assert.svh"

module lowest_free_id_tracker_core #(
  parameter int ID_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lfid_pkg::lfid_req_t req_i,
  output logic                done_o,
  output lfid_pkg::lfid_rsp_t rsp_o
);

  import lfid_pkg::*;

  localparam int DEPTH  = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = AW + BIT_W;
  localparam int MARK_W = POS_W + 1;

  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [MARK_W-1:0] FREE_SAT  = MARK_W'(ID_COUNT + 1);

  // Sequencer states.
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_OP   = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  lfid_dir_e         dir_q, dir_d;
  logic [MARK_W-1:0] free_q, free_d;
  logic [MARK_W-1:0] top_q, top_d;
  logic              ok_q, ok_d;
  logic              done_q, done_d;

  // Operation captured at the transfer.
  logic              mode_q;
  logic              inrange_q;
  logic [POS_W-1:0]  pos_q;

  logic [31:0]       ident_m1;
  logic              in_range;
  logic              accept;

  // Map RAM ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Current word of the operation.
  logic [AW-1:0]     word_a;
  logic [BIT_W-1:0]  bit_b;
  logic [WORD_W-1:0] onehot;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] mask_above;
  logic [WORD_W-1:0] mask_below;
  logic [MARK_W-1:0] id_mark;
  logic              bit_used;

  // Shared scan unit.
  logic [WORD_W-1:0] pick_vec;
  lfid_dir_e         cur_dir;
  logic [AW-1:0]     cur_addr;
  logic              pick_found;
  logic [BIT_W-1:0]  pick_pos;
  logic [MARK_W-1:0] pick_mark;
  logic              scan_go;
  logic              finish;

  logic [31:0]       free_ext;
  logic [31:0]       top_ext;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign ident_m1 = 32'(req_i.ident) - 32'd1;
  assign in_range = (req_i.ident != '0) && (32'(req_i.ident) <= 32'(ID_COUNT));

  assign word_a     = pos_q[POS_W-1:BIT_W];
  assign bit_b      = pos_q[BIT_W-1:0];
  assign onehot     = WORD_W'(1) << bit_b;
  assign bit_used   = |(ram_rdata & onehot);
  assign new_word   = (mode_q == MODE_ADD) ? (ram_rdata | onehot) : (ram_rdata & ~onehot);
  assign mask_above = ({WORD_W{1'b1}} << bit_b) << 1;
  assign mask_below = ~({WORD_W{1'b1}} << bit_b);
  assign id_mark    = MARK_W'(pos_q) + MARK_W'(1);

  // In the operation cycle the scan starts in the id's own word; later it
  // walks the words held in addr_q.
  assign cur_addr = (state_q == ST_OP) ? word_a : addr_q;
  assign cur_dir  = (state_q == ST_OP) ?
                    ((mode_q == MODE_ADD) ? DIR_UP : DIR_DOWN) : dir_q;
  assign pick_mark = MARK_W'({cur_addr, pick_pos}) + MARK_W'(1);

  lfid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lfid_pick u_pick (
    .vec_i   (pick_vec),
    .dir_i   (cur_dir),
    .found_o (pick_found),
    .pos_o   (pick_pos)
  );

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    dir_d     = dir_q;
    free_d    = free_q;
    top_d     = top_q;
    ok_d      = ok_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = word_a;
    ram_wdata = new_word;
    ram_raddr = ident_m1[POS_W-1:BIT_W];
    pick_vec  = '0;
    scan_go   = 1'b0;
    finish    = 1'b0;

    case (state_q)
      ST_CLR: begin
        // Sweep zeros through the map, one word a cycle.
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = '0;
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        // Read the id's word now so it is ready in the operation cycle.
        if (accept) begin
          state_d = ST_OP;
        end
      end
      ST_OP: begin
        if (!inrange_q) begin
          ok_d   = 1'b0;
          finish = 1'b1;
        end else if (mode_q == MODE_ADD) begin
          ram_we = 1'b1;
          ok_d   = 1'b1;
          top_d  = (id_mark > top_q) ? id_mark : top_q;
          if (id_mark == free_q) begin
            pick_vec = ~new_word & mask_above;
            scan_go  = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end else if (bit_used) begin
          ram_we = 1'b1;
          ok_d   = 1'b1;
          free_d = (id_mark < free_q) ? id_mark : free_q;
          if (id_mark == top_q) begin
            pick_vec = new_word & mask_below;
            scan_go  = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end else begin
          // Delete of an unused id: drop it.
          ok_d   = 1'b0;
          finish = 1'b1;
        end
      end
      ST_SCAN: begin
        pick_vec = (dir_q == DIR_UP) ? ~ram_rdata : ram_rdata;
        scan_go  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (scan_go) begin
      if (pick_found) begin
        if (cur_dir == DIR_UP) begin
          free_d = pick_mark;
        end else begin
          top_d = pick_mark;
        end
        finish = 1'b1;
      end else if ((cur_dir == DIR_UP) && (cur_addr == LAST_ADDR)) begin
        // Map full above: saturate.
        free_d = FREE_SAT;
        finish = 1'b1;
      end else if ((cur_dir == DIR_DOWN) && (cur_addr == '0)) begin
        // Map empty.
        top_d  = '0;
        finish = 1'b1;
      end else begin
        // Advance to the neighboring word and read it for the next cycle.
        addr_d    = (cur_dir == DIR_UP) ? (cur_addr + AW'(1)) : (cur_addr - AW'(1));
        ram_raddr = addr_d;
        dir_d     = cur_dir;
        state_d   = ST_SCAN;
      end
    end

    if (finish) begin
      done_d  = 1'b1;
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      addr_q  <= '0;
      dir_q   <= DIR_UP;
      free_q  <= MARK_W'(1);
      top_q   <= '0;
      ok_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      dir_q   <= dir_d;
      free_q  <= free_d;
      top_q   <= top_d;
      ok_q    <= ok_d;
      done_q  <= done_d;
    end
  end

  // Hold the transfer's operation until it completes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= req_i.mode;
      inrange_q <= in_range;
      pos_q     <= ident_m1[POS_W-1:0];
    end
  end

  assign free_ext = 32'(free_q);
  assign top_ext  = 32'(top_q);

  assign done_o            = done_q;
  assign rsp_o.ok           = ok_q;
  assign rsp_o.lowest_free  = free_ext[FIELD_W-1:0];
  assign rsp_o.highest_used = top_ext[FIELD_W-1:0];

  // A transfer always occupies the block in the following cycle.
  `LFID_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  // Results are shown only once the sequencer is back to idle.
  `LFID_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // Every result strobe lasts a single cycle.
  `LFID_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)
  // The lowest free mark never drops to zero.
  `LFID_ASSERT_IMP(a_free_nonzero, clk_i, rst_ni, 1'b1, free_q != '0)

endmodule
